/* rtl/ssi_pkg.sv */
// package for the segment intersection block: widths, status codes
// no dependencies
`default_nettype none
package ssi_pkg;
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int IN_BITS        = 16;
   localparam int OUT_BITS       = 32;

   typedef enum logic [1:0] {
      ST_CROSS    = 2'd0,
      ST_PARALLEL = 2'd1,
      ST_OUTSIDE  = 2'd2
   } status_type;
endpackage
`default_nettype wire

/* rtl/ssi_div_stage.sv */
// one restoring division step per stage, registered, with stall
// depends on ssi_pkg
`default_nettype none
module ssi_div_stage import ssi_pkg::*; #(
   parameter int DW = 36,
   parameter int QW = 17,
   parameter int PW = 36
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic          in_valid,
   input  wire logic [DW-1:0] in_rem,
   input  wire logic [DW-1:0] in_den,
   input  wire logic [QW-1:0] in_q,
   input  wire logic [PW-1:0] in_pay,
   output logic               out_valid,
   output logic [DW-1:0]      out_rem,
   output logic [DW-1:0]      out_den,
   output logic [QW-1:0]      out_q,
   output logic [PW-1:0]      out_pay
);
   logic          valid_ff;
   logic [DW-1:0] rem_ff, den_ff, rem_in;
   logic [QW-1:0] q_ff, q_in;
   logic [PW-1:0] pay_ff;
   logic [DW:0]   sh;

   // shift then trial subtract; remainder stays below den so DW+1 bits suffice
   always_comb begin
      sh = {in_rem, 1'b0};
      if (sh >= {1'b0, in_den}) begin
         rem_in = DW'(sh - {1'b0, in_den});
         q_in   = {in_q[QW-2:0], 1'b1};
      end else begin
         rem_in = sh[DW-1:0];
         q_in   = {in_q[QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         rem_ff <= rem_in;
         den_ff <= in_den;
         q_ff   <= q_in;
         pay_ff <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_q     = q_ff;
   assign out_pay   = pay_ff;
endmodule
`default_nettype wire

/* rtl/segment_segment_intersection_top.sv */
// top level of the 2d segment intersection pipeline
// depends on ssi_pkg and ssi_div_stage
// Fully pipelined: one segment pair per cycle while the result side does not
// stall. Stages: difference, six products, cross products, sign fix and
// bounds test, first quotient bit, one stage per fraction bit, point
// multiply, point add. The whole pipe advances together under a single
// enable: it moves whenever the output register is empty or its transfer is
// taken, so a stall on the result side holds every stage and nothing is lost
// or repeated. Results that miss (parallel or outside) ride through the
// divider as 0 divided by 1 and leave with zero point fields.
`default_nettype none
module segment_segment_intersection_top import ssi_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic signed [IN_BITS-1:0] req_a_start_x,
   input  wire logic signed [IN_BITS-1:0] req_a_start_y,
   input  wire logic signed [IN_BITS-1:0] req_a_end_x,
   input  wire logic signed [IN_BITS-1:0] req_a_end_y,
   input  wire logic signed [IN_BITS-1:0] req_b_start_x,
   input  wire logic signed [IN_BITS-1:0] req_b_start_y,
   input  wire logic signed [IN_BITS-1:0] req_b_end_x,
   input  wire logic signed [IN_BITS-1:0] req_b_end_y,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_hit,
   output logic [1:0]                rsp_status,
   output logic signed [OUT_BITS-1:0] rsp_cross_x,
   output logic signed [OUT_BITS-1:0] rsp_cross_y
);
   localparam int CW = COORD_BITS;
   localparam int RW = CW + 1;          // difference width
   localparam int PW = 2 * RW + 1;      // cross product width
   localparam int DW = PW + 1;          // divider remainder width
   localparam int QW = FRAC_BITS + 1;   // t from 0 to 1.0
   localparam int MW = RW + QW + 1;     // r * t product width
   localparam int SW = MW + 1;          // point sum width
   // payload through the divider: hit, status, asx, asy, rax, ray
   localparam int LW = 1 + 2 + 2 * CW + 2 * RW;

   // single enable for the whole pipe
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // stage 1: sign extend, differences
   logic              v1_ff;
   logic signed [CW-1:0] asx1_ff, asy1_ff;
   logic signed [RW-1:0] rax1_ff, ray1_ff, rbx1_ff, rby1_ff, dx1_ff, dy1_ff;
   logic signed [CW-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
   assign asx = req_a_start_x[CW-1:0];
   assign asy = req_a_start_y[CW-1:0];
   assign aex = req_a_end_x[CW-1:0];
   assign aey = req_a_end_y[CW-1:0];
   assign bsx = req_b_start_x[CW-1:0];
   assign bsy = req_b_start_y[CW-1:0];
   assign bex = req_b_end_x[CW-1:0];
   assign bey = req_b_end_y[CW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
      if (adv) begin
         asx1_ff <= asx;
         asy1_ff <= asy;
         rax1_ff <= RW'(aex) - RW'(asx);
         ray1_ff <= RW'(aey) - RW'(asy);
         rbx1_ff <= RW'(bex) - RW'(bsx);
         rby1_ff <= RW'(bey) - RW'(bsy);
         dx1_ff  <= RW'(bsx) - RW'(asx);
         dy1_ff  <= RW'(bsy) - RW'(asy);
      end
   end

   // stage 2: six products, registered before the subtracts
   logic                 v2_ff;
   logic signed [CW-1:0] asx2_ff, asy2_ff;
   logic signed [RW-1:0] rax2_ff, ray2_ff;
   logic signed [2*RW-1:0] p_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         asx2_ff <= asx1_ff;
         asy2_ff <= asy1_ff;
         rax2_ff <= rax1_ff;
         ray2_ff <= ray1_ff;
         p_ff[0] <= rax1_ff * rby1_ff;
         p_ff[1] <= ray1_ff * rbx1_ff;
         p_ff[2] <= dx1_ff * rby1_ff;
         p_ff[3] <= dy1_ff * rbx1_ff;
         p_ff[4] <= dx1_ff * ray1_ff;
         p_ff[5] <= dy1_ff * rax1_ff;
      end
   end

   // stage 3: cross products
   logic                 v3_ff;
   logic signed [CW-1:0] asx3_ff, asy3_ff;
   logic signed [RW-1:0] rax3_ff, ray3_ff;
   logic signed [PW-1:0] den3_ff, nt3_ff, nu3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         asx3_ff <= asx2_ff;
         asy3_ff <= asy2_ff;
         rax3_ff <= rax2_ff;
         ray3_ff <= ray2_ff;
         den3_ff <= PW'(p_ff[0]) - PW'(p_ff[1]);
         nt3_ff  <= PW'(p_ff[2]) - PW'(p_ff[3]);
         nu3_ff  <= PW'(p_ff[4]) - PW'(p_ff[5]);
      end
   end

   // stage 4: sign fix, bounds test, classify
   logic signed [PW:0] den_a, nt_a, nu_a;
   logic               hit_c;
   status_type         st_c;
   always_comb begin
      if (den3_ff < 0) begin
         den_a = -(PW+1)'(den3_ff);
         nt_a  = -(PW+1)'(nt3_ff);
         nu_a  = -(PW+1)'(nu3_ff);
      end else begin
         den_a = (PW+1)'(den3_ff);
         nt_a  = (PW+1)'(nt3_ff);
         nu_a  = (PW+1)'(nu3_ff);
      end
      hit_c = 1'b0;
      if (den3_ff == '0) begin
         st_c = ST_PARALLEL;
      end else if (nt_a < 0 || nt_a > den_a || nu_a < 0 || nu_a > den_a) begin
         st_c = ST_OUTSIDE;
      end else begin
         st_c  = ST_CROSS;
         hit_c = 1'b1;
      end
   end

   logic          v4_ff;
   logic [DW-1:0] rem4_ff, den4_ff;
   logic [LW-1:0] pay4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         // misses divide 0 by 1 so the datapath stays tame
         rem4_ff <= hit_c ? DW'(nt_a) : '0;
         den4_ff <= hit_c ? DW'(den_a) : DW'(1);
         pay4_ff <= {hit_c, st_c, asx3_ff, asy3_ff, rax3_ff, ray3_ff};
      end
   end

   // stage 5: integer quotient bit (t can be exactly 1.0)
   logic          v5_ff;
   logic [DW-1:0] rem5_ff, den5_ff;
   logic [QW-1:0] q5_ff;
   logic [LW-1:0] pay5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
      if (adv) begin
         den5_ff <= den4_ff;
         pay5_ff <= pay4_ff;
         if (rem4_ff >= den4_ff) begin
            rem5_ff <= rem4_ff - den4_ff;
            q5_ff   <= QW'(1);
         end else begin
            rem5_ff <= rem4_ff;
            q5_ff   <= '0;
         end
      end
   end

   // fraction bits, one stage each
   logic          dv   [FRAC_BITS+1];
   logic [DW-1:0] drem [FRAC_BITS+1];
   logic [DW-1:0] dden [FRAC_BITS+1];
   logic [QW-1:0] dq   [FRAC_BITS+1];
   logic [LW-1:0] dpay [FRAC_BITS+1];

   assign dv[0]   = v5_ff;
   assign drem[0] = rem5_ff;
   assign dden[0] = den5_ff;
   assign dq[0]   = q5_ff;
   assign dpay[0] = pay5_ff;

   for (genvar g = 0; g < FRAC_BITS; g++) begin : g_div
      ssi_div_stage #(.DW(DW), .QW(QW), .PW(LW)) u_step (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_valid (dv[g]),
         .in_rem   (drem[g]),
         .in_den   (dden[g]),
         .in_q     (dq[g]),
         .in_pay   (dpay[g]),
         .out_valid(dv[g+1]),
         .out_rem  (drem[g+1]),
         .out_den  (dden[g+1]),
         .out_q    (dq[g+1]),
         .out_pay  (dpay[g+1])
      );
   end

   // unpack divider payload
   logic                 hit_d;
   logic [1:0]           st_d;
   logic signed [CW-1:0] asx_d, asy_d;
   logic signed [RW-1:0] rax_d, ray_d;
   assign {hit_d, st_d, asx_d, asy_d, rax_d, ray_d} = dpay[FRAC_BITS];

   // point multiply stage
   logic                 v6_ff, hit6_ff;
   logic [1:0]           st6_ff;
   logic signed [CW-1:0] asx6_ff, asy6_ff;
   logic signed [MW-1:0] mx6_ff, my6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= dv[FRAC_BITS];
      end
      if (adv) begin
         hit6_ff <= hit_d;
         st6_ff  <= st_d;
         asx6_ff <= asx_d;
         asy6_ff <= asy_d;
         mx6_ff  <= MW'(rax_d) * MW'($signed({1'b0, dq[FRAC_BITS]}));
         my6_ff  <= MW'(ray_d) * MW'($signed({1'b0, dq[FRAC_BITS]}));
      end
   end

   // point add, output register
   logic signed [SW-1:0] px, py;
   assign px = (SW'(asx6_ff) <<< FRAC_BITS) + SW'(mx6_ff);
   assign py = (SW'(asy6_ff) <<< FRAC_BITS) + SW'(my6_ff);

   logic                       ov_ff, ohit_ff;
   logic [1:0]                 ost_ff;
   logic signed [OUT_BITS-1:0] ox_ff, oy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= v6_ff;
      end
      if (adv) begin
         ohit_ff <= hit6_ff;
         ost_ff  <= st6_ff;
         ox_ff   <= hit6_ff ? OUT_BITS'(px) : '0;
         oy_ff   <= hit6_ff ? OUT_BITS'(py) : '0;
      end
   end

   assign rsp_valid   = ov_ff;
   assign rsp_hit     = ohit_ff;
   assign rsp_status  = ost_ff;
   assign rsp_cross_x = ox_ff;
   assign rsp_cross_y = oy_ff;
endmodule
`default_nettype wire

/* dv/tb.sv */
// testbench for segment_segment_intersection_top: directed table then random pairs
// depends on ssi_pkg and the rtl of the intersection pipeline
`default_nettype none
module tb import ssi_pkg::*;;

   localparam int NUM_RANDOM = 700;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [IN_BITS-1:0] req_a_start_x = '0, req_a_start_y = '0;
   logic signed [IN_BITS-1:0] req_a_end_x = '0, req_a_end_y = '0;
   logic signed [IN_BITS-1:0] req_b_start_x = '0, req_b_start_y = '0;
   logic signed [IN_BITS-1:0] req_b_end_x = '0, req_b_end_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic rsp_hit;
   logic [1:0] rsp_status;
   logic signed [OUT_BITS-1:0] rsp_cross_x, rsp_cross_y;

   typedef struct packed {
      logic signed [IN_BITS-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
   } seg_pair_type;

   typedef struct packed {
      logic hit;
      status_type status;
      logic signed [OUT_BITS-1:0] cx, cy;
   } crossing_type;

   // directed row: pair, and optional typed-in expectation
   typedef struct packed {
      seg_pair_type pair;
      logic has_fixed;
      crossing_type fixed;
   } row_type;

   crossing_type pending_crossings[$];
   int mismatch_count = 0;
   int received_count = 0;
   logic stimulus_done = 1'b0;
   logic no_idle = 1'b0;     // long stretch with no idling on either side
   logic hold_off = 1'b0;    // receiver holds off for a long stretch

   segment_segment_intersection_top dut (.*);

   always #10 clock = ~clock;

   // integer-exact crossing computation at default widths
   function automatic crossing_type crossing_of(seg_pair_type p);
      crossing_type r;
      longint rax, ray, rbx, rby, dx, dy, den, nt, nu, q, rem, px, py;
      r = '0;
      r.status = ST_CROSS;
      rax = longint'(p.aex) - p.asx;
      ray = longint'(p.aey) - p.asy;
      rbx = longint'(p.bex) - p.bsx;
      rby = longint'(p.bey) - p.bsy;
      dx = longint'(p.bsx) - p.asx;
      dy = longint'(p.bsy) - p.asy;
      den = rax * rby - ray * rbx;
      nt = dx * rby - dy * rbx;
      nu = dx * ray - dy * rax;
      if (den == 0) begin
         r.status = ST_PARALLEL;
         return r;
      end
      if (den < 0) begin
         den = -den;
         nt = -nt;
         nu = -nu;
      end
      if (nt < 0 || nt > den || nu < 0 || nu > den) begin
         r.status = ST_OUTSIDE;
         return r;
      end
      // restoring division for t as unsigned fraction
      q = 0;
      rem = nt;
      if (rem >= den) begin
         q = 1;
         rem -= den;
      end
      for (int i = 0; i < FRAC_BITS_DEF; i++) begin
         rem = rem <<< 1;
         q = q <<< 1;
         if (rem >= den) begin
            rem -= den;
            q |= 1;
         end
      end
      px = longint'(p.asx) * (longint'(1) <<< FRAC_BITS_DEF) + rax * q;
      py = longint'(p.asy) * (longint'(1) <<< FRAC_BITS_DEF) + ray * q;
      r.hit = 1'b1;
      r.cx = px[31:0];
      r.cy = py[31:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on result %0d: %s got %0d want %0d",
               received_count, what, got, want);
      mismatch_count++;
   endtask

   function automatic seg_pair_type mk(int a, int b, int c, int d,
                                       int e, int f, int g, int h);
      seg_pair_type p;
      p.asx = a; p.asy = b; p.aex = c; p.aey = d;
      p.bsx = e; p.bsy = f; p.bex = g; p.bey = h;
      return p;
   endfunction

   function automatic crossing_type fix(logic h, status_type s, int x, int y);
      crossing_type r;
      r.hit = h; r.status = s; r.cx = x; r.cy = y;
      return r;
   endfunction

   // biased coordinate: extremes, small values, or full range
   function automatic logic signed [IN_BITS-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1, 2: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
         default: return 16'($urandom);
      endcase
   endfunction

   // half the pairs built around a shared point, some parallel, the rest noise
   function automatic seg_pair_type rand_pair();
      seg_pair_type p;
      int cx, cy, sel;
      sel = $urandom_range(0, 9);
      p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      if (sel < 5) begin
         cx = $signed(16'($urandom_range(0, 2000))) - 1000;
         cy = $signed(16'($urandom_range(0, 2000))) - 1000;
         p.asx = cx - $urandom_range(0, 500); p.aex = cx + $urandom_range(0, 500);
         p.asy = cy - $urandom_range(0, 500); p.aey = cy + $urandom_range(0, 500);
         p.bsx = cx + $urandom_range(0, 500); p.bex = cx - $urandom_range(0, 500);
         p.bsy = cy - $urandom_range(0, 500); p.bey = cy + $urandom_range(0, 500);
      end else if (sel == 5) begin
         // parallel: b direction equals a direction
         p.bex = p.bsx + (p.aex - p.asx);
         p.bey = p.bsy + (p.aey - p.asy);
      end
      return p;
   endfunction

   task automatic send_pair(seg_pair_type p);
      {req_a_start_x, req_a_start_y, req_a_end_x, req_a_end_y,
       req_b_start_x, req_b_start_y, req_b_end_x, req_b_end_y} = p;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // idle cycle by cycle: each further gap follows with chance 29 in 100, none under no_idle
   task automatic idle_sender();
      while (!no_idle && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   // stimulus
   initial begin
      row_type rows[$];
      seg_pair_type p;
      rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1, fix(0, ST_PARALLEL, 0, 0)});
      rows.push_back('{mk(0, 0, 10, 0, 0, 5, 10, 5), 1, fix(0, ST_PARALLEL, 0, 0)});
      rows.push_back('{mk(0, 0, 10, 0, 20, 0, 30, 0), 1, fix(0, ST_PARALLEL, 0, 0)});
      rows.push_back('{mk(0, 0, 2, 0, 1, -1, 1, 1), 1,
                       fix(1, ST_CROSS, 32'h0001_0000, 0)});
      rows.push_back('{mk(0, 0, 2, 0, 5, -1, 5, 1), 1, fix(0, ST_OUTSIDE, 0, 0)});
      rows.push_back('{mk(0, 0, 2, 0, 1, 1, 1, 3), 1, fix(0, ST_OUTSIDE, 0, 0)});
      // touching at endpoints
      rows.push_back('{mk(0, 0, 4, 0, 4, 0, 4, 4), 1,
                       fix(1, ST_CROSS, 32'h0004_0000, 0)});
      rows.push_back('{mk(0, 0, 4, 4, 0, 0, -4, 4), 1, fix(1, ST_CROSS, 0, 0)});
      rows.push_back('{mk(0, 0, 3, 0, 1, -1, 1, 1), 0, '0});
      rows.push_back('{mk(0, 0, 1, 1, 1, 0, 0, 1), 0, '0});
      rows.push_back('{mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768),
                       0, '0});
      rows.push_back('{mk(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767),
                       0, '0});
      rows.push_back('{mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 0, '0});
      rows.push_back('{mk(32767, 0, -32768, 0, 0, 32767, 0, -32768), 0, '0});
      rows.push_back('{mk(-1, -1, -1, -1, -1, -1, -1, -1), 1,
                       fix(0, ST_PARALLEL, 0, 0)});
      rows.push_back('{mk(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767),
                       1, fix(0, ST_PARALLEL, 0, 0)});
      rows.push_back('{mk(0, 0, 7, 3, 2, 5, 5, -4), 0, '0});
      rows.push_back('{mk(-5, 3, 9, -8, -6, -7, 8, 6), 0, '0});

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         pending_crossings.push_back(rows[i].has_fixed ? rows[i].fixed
                                                       : crossing_of(rows[i].pair));
         send_pair(rows[i].pair);
         idle_sender();
      end

      for (int n = 0; n < NUM_RANDOM; n++) begin
         no_idle = (n >= 200 && n < 300);
         hold_off = (n >= 400 && n < 440);
         if (n == 550) begin
            // sender pauses until the pipe has drained
            req_valid <= 1'b0;
            wait (pending_crossings.size() == 0);
            @(negedge clock);
         end
         p = rand_pair();
         pending_crossings.push_back(crossing_of(p));
         send_pair(p);
         idle_sender();
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;
      hold_off = 1'b0;
      stimulus_done = 1'b1;
   end

   // receiver stall, with a long counted hold-off
   initial begin
      int held;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_off) begin
            held = 0;
            rsp_stall <= 1'b1;
            while (held < 120) begin
               @(negedge clock);
               held++;
            end
            rsp_stall <= 1'b0;
            wait (!hold_off);
         end else begin
            rsp_stall <= (!no_idle && $urandom_range(0, 99) < 29);
         end
      end
   end

   // result check at the rising edge
   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_crossings.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = pending_crossings.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_cross_x !== want.cx) report_mismatch("cross_x", rsp_cross_x, want.cx);
            if (rsp_cross_y !== want.cy) report_mismatch("cross_y", rsp_cross_y, want.cy);
         end
         received_count++;
      end
   end

   // end of run
   initial begin
      wait (stimulus_done);
      wait (pending_crossings.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
`default_nettype wire
